// ===== design/rrc_pkg.sv =====
// Shared constants, angle table and queue status type for the rotated rectangle block.
package rrc_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int TRIG_STEPS_DEF = 16;

	localparam int ANGLE_BITS   = 17;
	localparam int TRIG_W       = 32;
	localparam int Z_W          = 33;
	localparam int ATAN_ENTRIES = 24;

	localparam logic signed [ANGLE_BITS:0] FULL_TURN    = 18'sd46080;
	localparam logic signed [ANGLE_BITS:0] QUARTER_TURN = 18'sd11520;
	localparam logic signed [TRIG_W-1:0]   HALF_GAIN    = 32'sd326016437;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// atan(2^-i) in degrees, 24 fraction bits
	localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
		33'sd754974720, 33'sd445687602, 33'sd235489089, 33'sd119537938,
		33'sd60000934, 33'sd30029717, 33'sd15018523, 33'sd7509720,
		33'sd3754917, 33'sd1877466, 33'sd938734, 33'sd469367,
		33'sd234684, 33'sd117342, 33'sd58671, 33'sd29335,
		33'sd14668, 33'sd7334, 33'sd3667, 33'sd1833,
		33'sd917, 33'sd458, 33'sd229, 33'sd115
	};

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ===== design/rrc_fifo.sv =====
// Short queue between the trig front end and the geometry back end.
module rrc_fifo #(
	parameter int W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [W-1:0]        wdata,
	input  logic                pop,
	output logic [W-1:0]        rdata,
	output rrc_pkg::fifo_stat_t stat
);
	import rrc_pkg::*;

	localparam int DEPTH = 4;

	logic [W-1:0] mem_q [DEPTH];
	logic [1:0]   wptr_q, rptr_q;
	logic [2:0]   cnt_q;

	assign stat.full  = (cnt_q == 3'(DEPTH));
	assign stat.empty = (cnt_q == 3'd0);
	assign rdata      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 2'd1;
			if (pop)  rptr_q <= rptr_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

endmodule

// ===== design/rrc_front.sv =====
// Front end: angle reduction, pipelined CORDIC, quadrant mapping.
module rrc_front #(
	parameter int COORD_BITS = rrc_pkg::COORD_BITS_DEF,
	parameter int TRIG_STEPS = rrc_pkg::TRIG_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic [COORD_BITS-2:0]         box_width,
	input  logic [COORD_BITS-2:0]         box_height,
	input  logic signed [rrc_pkg::ANGLE_BITS-1:0] angle_deg,
	output logic                          push,
	output logic [4*COORD_BITS+2*rrc_pkg::TRIG_W-3:0] push_data,
	input  rrc_pkg::fifo_stat_t           stat
);
	import rrc_pkg::*;

	localparam int N = TRIG_STEPS;

	logic                          v_q  [N+1];
	logic signed [TRIG_W-1:0]      x_q  [N+1];
	logic signed [TRIG_W-1:0]      y_q  [N+1];
	logic signed [Z_W-1:0]         z_q  [N+1];
	logic [1:0]                    qd_q [N+1];
	logic signed [COORD_BITS-1:0]  cx_q [N+1];
	logic signed [COORD_BITS-1:0]  cy_q [N+1];
	logic [COORD_BITS-2:0]         w_q  [N+1];
	logic [COORD_BITS-2:0]         h_q  [N+1];

	logic en;
	logic signed [ANGLE_BITS:0] a0, a1, a2, rem;
	logic [1:0] quad;
	logic signed [TRIG_W-1:0] hc, hs;

	assign en       = !v_q[N] || !stat.full;
	assign in_ready = en;
	assign push     = v_q[N] && !stat.full;

	// fold into [0, 360) degrees, then split off the quadrant
	always_comb begin
		a0 = (ANGLE_BITS+1)'(angle_deg);
		if (a0 < 0) a1 = a0 + FULL_TURN;
		else if (a0 >= FULL_TURN) a1 = a0 - FULL_TURN;
		else a1 = a0;
		a2 = (a1 < 0) ? a1 + FULL_TURN : a1;
		if (a2 >= 3 * QUARTER_TURN) begin
			quad = QUAD_3;
			rem  = a2 - (ANGLE_BITS+1)'(3 * QUARTER_TURN);
		end else if (a2 >= 2 * QUARTER_TURN) begin
			quad = QUAD_2;
			rem  = a2 - (ANGLE_BITS+1)'(2 * QUARTER_TURN);
		end else if (a2 >= QUARTER_TURN) begin
			quad = QUAD_1;
			rem  = a2 - QUARTER_TURN;
		end else begin
			quad = QUAD_0;
			rem  = a2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q[0] <= 1'b0;
		else if (en) v_q[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]  <= HALF_GAIN;
			y_q[0]  <= '0;
			z_q[0]  <= Z_W'(rem) <<< 17;
			qd_q[0] <= quad;
			cx_q[0] <= center_x;
			cy_q[0] <= center_y;
			w_q[0]  <= box_width;
			h_q[0]  <= box_height;
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[k] <= 1'b0;
			else if (en) v_q[k] <= v_q[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_q[k-1] >= 0) begin
					x_q[k] <= x_q[k-1] - (y_q[k-1] >>> (k-1));
					y_q[k] <= y_q[k-1] + (x_q[k-1] >>> (k-1));
					z_q[k] <= z_q[k-1] - ATAN_TAB[k-1];
				end else begin
					x_q[k] <= x_q[k-1] + (y_q[k-1] >>> (k-1));
					y_q[k] <= y_q[k-1] - (x_q[k-1] >>> (k-1));
					z_q[k] <= z_q[k-1] + ATAN_TAB[k-1];
				end
				qd_q[k] <= qd_q[k-1];
				cx_q[k] <= cx_q[k-1];
				cy_q[k] <= cy_q[k-1];
				w_q[k]  <= w_q[k-1];
				h_q[k]  <= h_q[k-1];
			end
		end
	end

	always_comb begin
		case (qd_q[N])
			QUAD_0:  begin hc = x_q[N];  hs = y_q[N];  end
			QUAD_1:  begin hc = -y_q[N]; hs = x_q[N];  end
			QUAD_2:  begin hc = -x_q[N]; hs = -y_q[N]; end
			default: begin hc = y_q[N];  hs = -x_q[N]; end
		endcase
	end

	assign push_data = {cx_q[N], cy_q[N], w_q[N], h_q[N], hc, hs};

endmodule

// ===== design/rrc_back.sv =====
// Back end: corner products, rounding, mirroring, saturation and bounding box.
module rrc_back #(
	parameter int COORD_BITS = rrc_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rrc_pkg::fifo_stat_t                  stat,
	input  logic [4*COORD_BITS+2*rrc_pkg::TRIG_W-3:0] pop_data,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [12*COORD_BITS-19:0]            out_data
);
	import rrc_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int PW = TRIG_W + CB;
	localparam int SW = CB + 33;
	localparam int RW = SW - 30;
	localparam int MW = CB + 4;
	localparam int BW = CB - 5;
	localparam logic signed [CB:0] CLO = {1'b1, {CB{1'b0}}};
	localparam logic signed [CB:0] CHI = {1'b0, {CB{1'b1}}};
	localparam logic signed [BW-1:0] BMAX = BW'(1) <<< (CB - 7);

	function automatic logic signed [CB:0] sat_c(input logic signed [MW-1:0] v);
		if (v < MW'(CLO)) return CLO;
		if (v > MW'(CHI)) return CHI;
		return v[CB:0];
	endfunction

	function automatic logic signed [CB:0] mn(input logic signed [CB:0] a, b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [CB:0] mx(input logic signed [CB:0] a, b);
		return (a > b) ? a : b;
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [CB-1:0]     cx_in, cy_in;
	logic [CB-2:0]            w_in, h_in;
	logic signed [TRIG_W-1:0] hc_in, hs_in;

	logic signed [CB-1:0] cx_s1, cy_s1, cx_s2, cy_s2;
	logic signed [PW-1:0] hs_h_s1, hc_w_s1, hc_h_s1, hs_w_s1;
	logic signed [RW-1:0] r0_s2, r1_s2, r2_s2, r3_s2;
	logic signed [CB:0]   px_s3 [4];
	logic signed [CB:0]   py_s3 [4];
	logic signed [CB:0]   minx_s4, maxx_s4, miny_s4, maxy_s4;
	logic signed [CB:0]   px_s4 [4];
	logic signed [CB:0]   py_s4 [4];
	logic [CB:0]          px_s5 [4];
	logic [CB:0]          py_s5 [4];
	logic [CB-8:0]        left_s5, top_s5;
	logic [CB-7:0]        bw_s5, bh_s5;

	logic signed [SW-1:0] sum0, sum1, sum2, sum3;
	logic signed [MW-1:0] m0x, m0y, m1x, m1y;
	logic signed [CB+1:0] ceilx, ceily;
	logic signed [BW-1:0] wx, wy;

	assign {cx_in, cy_in, w_in, h_in, hc_in, hs_in} = pop_data;

	assign en        = !v_s5 || out_ready;
	assign pop       = en && !stat.empty;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= !stat.empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// centers in Q.30 plus products, rounded half up to Q.8
	always_comb begin
		sum0 = (SW'(cx_s1) <<< 30) - SW'(hs_h_s1) - SW'(hc_w_s1) + (SW'(1) <<< 29);
		sum1 = (SW'(cy_s1) <<< 30) + SW'(hc_h_s1) - SW'(hs_w_s1) + (SW'(1) <<< 29);
		sum2 = (SW'(cx_s1) <<< 30) + SW'(hs_h_s1) - SW'(hc_w_s1) + (SW'(1) <<< 29);
		sum3 = (SW'(cy_s1) <<< 30) - SW'(hc_h_s1) - SW'(hs_w_s1) + (SW'(1) <<< 29);
		m0x  = (MW'(cx_s2) <<< 1) - MW'(r0_s2);
		m0y  = (MW'(cy_s2) <<< 1) - MW'(r1_s2);
		m1x  = (MW'(cx_s2) <<< 1) - MW'(r2_s2);
		m1y  = (MW'(cy_s2) <<< 1) - MW'(r3_s2);
		ceilx = ((CB+2)'(maxx_s4) + (CB+2)'(255)) >>> 8;
		ceily = ((CB+2)'(maxy_s4) + (CB+2)'(255)) >>> 8;
		wx = BW'(ceilx) - BW'(minx_s4 >>> 8) + BW'(1);
		wy = BW'(ceily) - BW'(miny_s4 >>> 8) + BW'(1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1   <= cx_in;
			cy_s1   <= cy_in;
			hs_h_s1 <= PW'(hs_in) * PW'($signed({1'b0, h_in}));
			hc_w_s1 <= PW'(hc_in) * PW'($signed({1'b0, w_in}));
			hc_h_s1 <= PW'(hc_in) * PW'($signed({1'b0, h_in}));
			hs_w_s1 <= PW'(hs_in) * PW'($signed({1'b0, w_in}));

			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			r0_s2 <= sum0[SW-1:30];
			r1_s2 <= sum1[SW-1:30];
			r2_s2 <= sum2[SW-1:30];
			r3_s2 <= sum3[SW-1:30];

			px_s3[0] <= sat_c(MW'(r0_s2));
			py_s3[0] <= sat_c(MW'(r1_s2));
			px_s3[1] <= sat_c(MW'(r2_s2));
			py_s3[1] <= sat_c(MW'(r3_s2));
			px_s3[2] <= sat_c(m0x);
			py_s3[2] <= sat_c(m0y);
			px_s3[3] <= sat_c(m1x);
			py_s3[3] <= sat_c(m1y);

			for (int k = 0; k < 4; k++) begin
				px_s4[k] <= px_s3[k];
				py_s4[k] <= py_s3[k];
			end
			minx_s4 <= mn(mn(px_s3[0], px_s3[1]), mn(px_s3[2], px_s3[3]));
			maxx_s4 <= mx(mx(px_s3[0], px_s3[1]), mx(px_s3[2], px_s3[3]));
			miny_s4 <= mn(mn(py_s3[0], py_s3[1]), mn(py_s3[2], py_s3[3]));
			maxy_s4 <= mx(mx(py_s3[0], py_s3[1]), mx(py_s3[2], py_s3[3]));

			for (int k = 0; k < 4; k++) begin
				px_s5[k] <= px_s4[k];
				py_s5[k] <= py_s4[k];
			end
			left_s5 <= minx_s4[CB:8];
			top_s5  <= miny_s4[CB:8];
			bw_s5   <= (wx < 0) ? '0 : ((wx > BMAX) ? BMAX[CB-7:0] : wx[CB-7:0]);
			bh_s5   <= (wy < 0) ? '0 : ((wy > BMAX) ? BMAX[CB-7:0] : wy[CB-7:0]);
		end
	end

	assign out_data = {bh_s5, bw_s5, top_s5, left_s5,
		py_s5[3], px_s5[3], py_s5[2], px_s5[2],
		py_s5[1], px_s5[1], py_s5[0], px_s5[0]};

endmodule

// ===== design/rotated_rect_corners_bbox.sv =====
// Top level: rotated rectangle to corners and integer bounding box.
//
//  channel  dir  fields (tdata, lowest bit up)
//  s_*      in   center_x, center_y, box_width, box_height, angle_deg
//  m_*      out  corner0_x/y .. corner3_x/y, bbox_left, bbox_top, bbox_width, bbox_height
//
// One rectangle per cycle sustained while m_tready stays high. The pipeline runs from the
// angle-reduction register through a register for each CORDIC iteration and the queue to back-end registers _s1 to _s5.
// Reset clears only valid bits and the queue pointers and count. The front stalls only when the
// four-entry queue is full; the back end stalls on m_tready alone.
module rotated_rect_corners_bbox #(
	parameter int COORD_BITS = rrc_pkg::COORD_BITS_DEF,
	parameter int TRIG_STEPS = rrc_pkg::TRIG_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// center_x, center_y, box_width, box_height, angle_deg, zero pad
	input  logic [((4*COORD_BITS+rrc_pkg::ANGLE_BITS-2+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x,
	// corner3_y, bbox_left, bbox_top, bbox_width, bbox_height, zero pad
	output logic [((12*COORD_BITS-18+7)/8)*8-1:0] m_tdata
);
	import rrc_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int IW  = 4*CB + ANGLE_BITS - 2;
	localparam int OW  = 12*CB - 18;
	localparam int QW  = 4*CB + 2*TRIG_W - 2;
	localparam int OWP = ((OW + 7) / 8) * 8;

	logic          push, pop;
	logic [QW-1:0] qin, qout;
	fifo_stat_t    stat;
	logic [OW-1:0] odata;

	rrc_front #(.COORD_BITS(COORD_BITS), .TRIG_STEPS(TRIG_STEPS)) u_front (
		.clk, .arst_n,
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.center_x  ($signed(s_tdata[CB-1:0])),
		.center_y  ($signed(s_tdata[2*CB-1:CB])),
		.box_width (s_tdata[3*CB-2:2*CB]),
		.box_height(s_tdata[4*CB-3:3*CB-1]),
		.angle_deg ($signed(s_tdata[IW-1:4*CB-2])),
		.push,
		.push_data (qin),
		.stat
	);

	rrc_fifo #(.W(QW)) u_fifo (
		.clk, .arst_n,
		.push, .wdata(qin),
		.pop,  .rdata(qout),
		.stat
	);

	rrc_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk, .arst_n,
		.stat,
		.pop_data (qout),
		.pop,
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (odata)
	);

	assign m_tdata = OWP'(odata);

	// never write a full queue or read an empty one
	assert property (@(posedge clk) disable iff (!arst_n) !(push && stat.full))
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && stat.empty))
		else $error("pop from empty queue");
	// box width never exceeds its saturation limit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (odata[OW-(CB-6)-1:OW-2*(CB-6)] <= ((CB-6)'(1) << (CB-7))))
		else $error("box width beyond limit");
	// a stalled result stays in place
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(odata))
		else $error("result changed while stalled");

endmodule

// ===== tb/rotated_rect_corners_bbox_test.sv =====
// Stream testbench for the rotated rectangle corners and bounding box block.
`timescale 1ns / 1ps

module rotated_rect_corners_bbox_test;
	import rrc_pkg::*;

	localparam int CB = 24;
	localparam int STEPS = 16;
	localparam int SW = ((4*CB+ANGLE_BITS-2+7)/8)*8;
	localparam int MW = ((12*CB-18+7)/8)*8;
	localparam int ITEMS = 450;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] ang;
		logic [CB-2:0] h;
		logic [CB-2:0] w;
		logic signed [CB-1:0] cy;
		logic signed [CB-1:0] cx;
	} rect_t;

	typedef struct packed {
		logic [CB-7:0] bh;
		logic [CB-7:0] bw;
		logic signed [CB-8:0] top;
		logic signed [CB-8:0] left;
		logic signed [CB:0] p3y, p3x, p2y, p2x, p1y, p1x, p0y, p0x;
	} corners_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
	logic [SW-1:0] s_tdata = '0;
	logic [MW-1:0] m_tdata;
	rect_t pending[$];
	corners_t expected_corners[$];
	int errors = 0, gap = 0, burst = 0;
	bit feeding = 0;

	rotated_rect_corners_bbox dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint fdiv(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic corners_t predict_corners(rect_t r);
		corners_t o;
		longint a, q, z, x, y, t, hc, hs, cx, cy, w, h, lo, hi;
		longint px[4], py[4], mnx, mxx, mny, mxy, left, top, bw, bh;
		a = longint'(r.ang) % 46080;
		if (a < 0) a += 46080;
		q = a / 11520;
		z = (a - q*11520) * 131072;
		x = 326016437; y = 0;
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				t = x - fdiv(y, i); y = y + fdiv(x, i); z -= ATAN_TAB[i];
			end else begin
				t = x + fdiv(y, i); y = y - fdiv(x, i); z += ATAN_TAB[i];
			end
			x = t;
		end
		case (q)
			0: begin hc = x; hs = y; end
			1: begin hc = -y; hs = x; end
			2: begin hc = -x; hs = -y; end
			default: begin hc = y; hs = -x; end
		endcase
		cx = longint'(r.cx); cy = longint'(r.cy); w = longint'(r.w); h = longint'(r.h);
		px[0] = fdiv(cx*(64'sd1 <<< 30) - hs*h - hc*w + (64'sd1 <<< 29), 30);
		py[0] = fdiv(cy*(64'sd1 <<< 30) + hc*h - hs*w + (64'sd1 <<< 29), 30);
		px[1] = fdiv(cx*(64'sd1 <<< 30) + hs*h - hc*w + (64'sd1 <<< 29), 30);
		py[1] = fdiv(cy*(64'sd1 <<< 30) - hc*h - hs*w + (64'sd1 <<< 29), 30);
		px[2] = 2*cx - px[0]; py[2] = 2*cy - py[0];
		px[3] = 2*cx - px[1]; py[3] = 2*cy - py[1];
		lo = -(64'sd1 <<< CB); hi = (64'sd1 <<< CB) - 1;
		for (int k = 0; k < 4; k++) begin
			px[k] = clip(px[k], lo, hi);
			py[k] = clip(py[k], lo, hi);
		end
		mnx = px[0]; mxx = px[0]; mny = py[0]; mxy = py[0];
		for (int k = 1; k < 4; k++) begin
			if (px[k] < mnx) mnx = px[k];
			if (px[k] > mxx) mxx = px[k];
			if (py[k] < mny) mny = py[k];
			if (py[k] > mxy) mxy = py[k];
		end
		left = fdiv(mnx, 8);
		top = fdiv(mny, 8);
		bw = clip(-fdiv(-mxx, 8) - left + 1, 0, 64'sd1 <<< (CB-7));
		bh = clip(-fdiv(-mxy, 8) - top + 1, 0, 64'sd1 <<< (CB-7));
		o.p0x = (CB+1)'(px[0]); o.p0y = (CB+1)'(py[0]);
		o.p1x = (CB+1)'(px[1]); o.p1y = (CB+1)'(py[1]);
		o.p2x = (CB+1)'(px[2]); o.p2y = (CB+1)'(py[2]);
		o.p3x = (CB+1)'(px[3]); o.p3y = (CB+1)'(py[3]);
		o.left = (CB-7)'(left); o.top = (CB-7)'(top);
		o.bw = (CB-6)'(bw); o.bh = (CB-6)'(bh);
		return o;
	endfunction

	// Sender: bursts with random gaps; hold the item until its transaction completes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_corners.push_back(predict_corners(rect_t'(s_tdata[$bits(rect_t)-1:0])));
			end
			if (!s_tvalid || s_tready) begin
				if (gap > 0) begin
					gap <= gap - 1;
					s_tvalid <= 0;
				end else if (feeding && pending.size() > 0) begin
					s_tdata <= SW'(pending.pop_front());
					s_tvalid <= 1;
					if (burst <= 1) begin
						burst <= $urandom_range(1, 30);
						gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else
						burst <= burst - 1;
				end else
					s_tvalid <= 0;
			end
		end
	end

	// Receiver: compare each transaction with the oldest prediction; stall on its own pattern.
	always @(posedge clk) begin
		corners_t got, exp_c;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = corners_t'(m_tdata[$bits(corners_t)-1:0]);
				if (expected_corners.size() == 0) begin
					$error("result with no expectation: %h", got);
					errors++;
				end else begin
					exp_c = expected_corners.pop_front();
					if (got.p0x !== exp_c.p0x) begin $error("corner0_x exp %0d got %0d", exp_c.p0x, got.p0x); errors++; end
					if (got.p0y !== exp_c.p0y) begin $error("corner0_y exp %0d got %0d", exp_c.p0y, got.p0y); errors++; end
					if (got.p1x !== exp_c.p1x) begin $error("corner1_x exp %0d got %0d", exp_c.p1x, got.p1x); errors++; end
					if (got.p1y !== exp_c.p1y) begin $error("corner1_y exp %0d got %0d", exp_c.p1y, got.p1y); errors++; end
					if (got.p2x !== exp_c.p2x) begin $error("corner2_x exp %0d got %0d", exp_c.p2x, got.p2x); errors++; end
					if (got.p2y !== exp_c.p2y) begin $error("corner2_y exp %0d got %0d", exp_c.p2y, got.p2y); errors++; end
					if (got.p3x !== exp_c.p3x) begin $error("corner3_x exp %0d got %0d", exp_c.p3x, got.p3x); errors++; end
					if (got.p3y !== exp_c.p3y) begin $error("corner3_y exp %0d got %0d", exp_c.p3y, got.p3y); errors++; end
					if (got.left !== exp_c.left) begin $error("bbox_left exp %0d got %0d", exp_c.left, got.left); errors++; end
					if (got.top !== exp_c.top) begin $error("bbox_top exp %0d got %0d", exp_c.top, got.top); errors++; end
					if (got.bw !== exp_c.bw) begin $error("bbox_width exp %0d got %0d", exp_c.bw, got.bw); errors++; end
					if (got.bh !== exp_c.bh) begin $error("bbox_height exp %0d got %0d", exp_c.bh, got.bh); errors++; end
				end
			end
			case (($time / 2000) % 3)
				0: m_tready <= 1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	function automatic rect_t rand_rect();
		rect_t r;
		int mode;
		mode = $urandom_range(0, 9);
		r.cx = CB'($urandom); r.cy = CB'($urandom);
		r.w = (CB-1)'($urandom); r.h = (CB-1)'($urandom);
		if (mode < 6) begin
			// typical boxes of modest size near the origin
			r.cx = CB'(int'($urandom_range(0, 200000)) - 100000);
			r.cy = CB'(int'($urandom_range(0, 200000)) - 100000);
			r.w = (CB-1)'($urandom_range(0, 60000));
			r.h = (CB-1)'($urandom_range(0, 60000));
		end
		if (mode == 9) r.ang = ANGLE_BITS'($urandom);
		else r.ang = ANGLE_BITS'(int'($urandom_range(0, 92160)) - 46080);
		if ($urandom_range(0, 7) == 0)
			r.ang = ANGLE_BITS'(11520 * int'($urandom_range(0, 8)) - 46080);
		return r;
	endfunction

	function automatic rect_t mk(int cx, int cy, int w, int h, int ang);
		rect_t r;
		r.cx = CB'(cx); r.cy = CB'(cy); r.w = (CB-1)'(w); r.h = (CB-1)'(h);
		r.ang = ANGLE_BITS'(ang);
		return r;
	endfunction

	initial begin
		int wait_cycles;
		pending.push_back(mk(0, 0, 0, 0, 0));
		pending.push_back(mk(2560, -2560, 2560, 1280, 0));
		pending.push_back(mk(2560, 2560, 2560, 1280, 11520));
		pending.push_back(mk(-2560, 2560, 2560, 1280, 23040));
		pending.push_back(mk(100, 200, 2560, 1280, 34560));
		pending.push_back(mk(100, 200, 2560, 1280, 46080));
		pending.push_back(mk(100, 200, 2560, 1280, -46080));
		pending.push_back(mk(100, 200, 2560, 1280, -11520));
		pending.push_back(mk(100, 200, 3000, 700, 5760));
		pending.push_back(mk(0, 0, 3000, 700, 65535));
		pending.push_back(mk(0, 0, 3000, 700, -65536));
		pending.push_back(mk(8388607, 8388607, 8388607, 8388607, 5760));
		pending.push_back(mk(-8388608, -8388608, 8388607, 8388607, 5760));
		pending.push_back(mk(8388607, -8388608, 8388607, 0, 17280));
		pending.push_back(mk(-8388608, 8388607, 0, 8388607, 1));
		pending.push_back(mk(0, 0, 8388607, 8388607, 0));
		pending.push_back(mk(-1, -1, 1, 1, 127));
		pending.push_back(mk(8388607, 8388607, 8388607, 8388607, -5760));
		for (int i = 0; i < ITEMS; i++) pending.push_back(rand_rect());
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		feeding <= 1;
		wait (pending.size() == 0 && !s_tvalid);
		wait_cycles = 0;
		while (expected_corners.size() > 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (STEPS + 20) @(posedge clk);
		if (errors == 0 && expected_corners.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
